/* rtl/core/assert_macros.svh */
// Shared assertion forms for the scrollback ring blocks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SRIM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srim assertion failed");

// Next-cycle implication, disabled during reset.
`define SRIM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srim assertion failed");

`endif

/* rtl/core/srim_pkg.sv */
package srim_pkg;

   localparam int RING_DEPTH = 1024;
   localparam int SLOT_W     = $clog2(RING_DEPTH);

   localparam int FIELD_W    = 10;
   localparam int HIST_W     = 10;
   localparam int ROWS_W     = 8;
   localparam int OP_W       = 3;
   localparam int DELTA_W    = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   // step counter holds the magnitude of the most negative delta
   localparam int CNT_W      = DELTA_W;
   // dividend of the modulo unit: head + ring size + row
   localparam int VAL_W      = ((SLOT_W > ROWS_W) ? SLOT_W : ROWS_W) + 2;
   localparam int MOD_CNT_W  = $clog2(VAL_W + 1);
   // offset + delta before clamping
   localparam int OFS_SUM_W  = (((SLOT_W + 1) > DELTA_W) ? (SLOT_W + 1) : DELTA_W) + 1;

   localparam logic [HIST_W-1:0] HIST_RESET = HIST_W'(1023);
   localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(24);

   typedef enum logic [OP_W-1:0] {
      OP_SCROLL      = 3'd0,
      OP_MOVE_OFS    = 3'd1,
      OP_RESET_OFS   = 3'd2,
      OP_MAP_SCREEN  = 3'd3,
      OP_MAP_VISIBLE = 3'd4
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HISTORY = 1'b0,
      REG_ROWS    = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MODWAIT,
      ST_FWD,
      ST_BACK,
      ST_OFFSET,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_status_type;

endpackage

/* rtl/core/srim_if.sv */
interface srim_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [srim_pkg::OP_W-1:0]            opcode;
   logic signed [srim_pkg::DELTA_W-1:0]  delta;
   logic [srim_pkg::ROWS_W-1:0]          row;

   modport source (output valid, output opcode, output delta, output row, input ready);
   modport sink   (input valid, input opcode, input delta, input row, output ready);
endinterface

interface srim_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [srim_pkg::FIELD_W-1:0]   line_slot;
   logic [srim_pkg::FIELD_W-1:0]   recycled_count;
   logic [srim_pkg::FIELD_W-1:0]   history_count;
   logic [srim_pkg::FIELD_W-1:0]   view_offset;

   modport source (output valid, output line_slot, output recycled_count,
                   output history_count, output view_offset, input ready);
   modport sink   (input valid, input line_slot, input recycled_count,
                   input history_count, input view_offset, output ready);
endinterface

/* rtl/core/srim_mod.sv */
`include "assert_macros.svh"

// Restoring remainder unit: one dividend bit per cycle.
module srim_mod (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [srim_pkg::VAL_W-1:0]         value,
   input  logic [srim_pkg::SLOT_W:0]          modulus,
   output srim_pkg::mod_status_type           status,
   output logic [srim_pkg::SLOT_W-1:0]        remainder
);

   logic [srim_pkg::VAL_W-1:0]      shreg_ff, shreg_in;
   logic [srim_pkg::SLOT_W-1:0]     rem_ff, rem_in;
   logic [srim_pkg::SLOT_W:0]       mod_ff, mod_in;
   logic [srim_pkg::MOD_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [srim_pkg::SLOT_W:0]       trial;

   always_comb begin
      shreg_in = shreg_ff;
      rem_in   = rem_ff;
      mod_in   = mod_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, shreg_ff[srim_pkg::VAL_W-1]};
      if (start) begin
         shreg_in = value;
         rem_in   = '0;
         mod_in   = modulus;
         cnt_in   = srim_pkg::MOD_CNT_W'(srim_pkg::VAL_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // shift in the next bit, subtract when it fits
         shreg_in = {shreg_ff[srim_pkg::VAL_W-2:0], 1'b0};
         if (trial >= mod_ff) begin
            rem_in = srim_pkg::SLOT_W'(trial - mod_ff);
         end else begin
            rem_in = srim_pkg::SLOT_W'(trial);
         end
         cnt_in = cnt_ff - srim_pkg::MOD_CNT_W'(1);
         if (cnt_ff == srim_pkg::MOD_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      shreg_ff <= shreg_in;
      rem_ff   <= rem_in;
      mod_ff   <= mod_in;
      cnt_ff   <= cnt_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

   `SRIM_ASSERT_IMP(a_start_idle, clock, reset, start, !busy_ff)
   `SRIM_ASSERT_IMP(a_rem_range, clock, reset, done_ff, {1'b0, rem_ff} < mod_ff)
   `SRIM_ASSERT_IMP(a_done_after_busy, clock, reset, done_ff, !busy_ff && $past(busy_ff))

endmodule

/* rtl/core/scrollback_ring_index_manager_core.sv */
// channel  | dir | handshake          | payload
// req_ch   | in  | valid/ready        | opcode, delta, row
// rsp_ch   | out | valid/ready        | line_slot, recycled_count, history_count, view_offset
// csr      | in  | csr_wr_en (no ack) | csr_index, csr_wr_data
//
// One item at a time under a small sequencer; ready only in the idle state.
// Move offset passes through the offset state; reset offset, zero scroll and unused opcodes go straight to finish.
// Backward scroll: one slot per cycle, for at most |delta| slots, until head meets base.
// Row maps: one pass of the bit-serial modulo unit (12 steps).
// Forward scroll: one modulo pass, then delta head steps, one per cycle.
// Reset is synchronous; a finished result waits in the output register while a new item
// is accepted; the sequencer holds in finish while that register is full and not read.
`include "assert_macros.svh"

module scrollback_ring_index_manager_core (
   input  logic                                 clock,
   input  logic                                 reset,
   srim_req_if.sink                             req_ch,
   srim_rsp_if.source                           rsp_ch,
   input  logic                                 csr_wr_en,
   input  logic [srim_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [srim_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   localparam int SW = srim_pkg::SLOT_W;

   srim_pkg::state_type                state_ff, state_in;
   logic [srim_pkg::OP_W-1:0]          op_ff, op_in;
   logic signed [srim_pkg::DELTA_W-1:0] delta_ff, delta_in;
   logic [srim_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic [SW-1:0]                      head_ff, head_in;
   logic [SW-1:0]                      base_ff, base_in;
   logic [SW-1:0]                      offset_ff, offset_in;
   logic [SW-1:0]                      bot_ff, bot_in;
   logic [SW-1:0]                      slot_ff, slot_in;
   logic [srim_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [srim_pkg::HIST_W-1:0]        hist_reg_ff;
   logic [srim_pkg::ROWS_W-1:0]        rows_reg_ff;
   logic                               rsp_valid_ff;
   logic [srim_pkg::FIELD_W-1:0]       rsp_slot_ff, rsp_count_ff, rsp_hist_ff, rsp_ofs_ff;

   logic [SW-1:0]                      top_slot;
   logic [SW:0]                        ring_size;
   logic [srim_pkg::ROWS_W-1:0]        rows_eff;
   logic [srim_pkg::ROWS_W-1:0]        row_lim;
   logic [srim_pkg::ROWS_W-1:0]        row_clamp;
   logic [SW-1:0]                      head_next, head_prev, bot_next, base_next;
   logic [SW-1:0]                      hist_cnt;
   logic signed [srim_pkg::OFS_SUM_W-1:0] ofs_sum, hist_wide;
   logic [SW-1:0]                      ofs_clamped;
   logic                               rsp_load;
   logic                               mod_start;
   logic [srim_pkg::VAL_W-1:0]         mod_value;
   srim_pkg::mod_status_type           mod_status;
   logic [SW-1:0]                      mod_rem;

   srim_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .value     (mod_value),
      .modulus   (ring_size),
      .status    (mod_status),
      .remainder (mod_rem)
   );

   // effective configuration
   always_comb begin
      if (hist_reg_ff == '0) begin
         top_slot = SW'(1);
      end else if (int'(hist_reg_ff) > srim_pkg::RING_DEPTH - 1) begin
         top_slot = SW'(srim_pkg::RING_DEPTH - 1);
      end else begin
         top_slot = SW'(hist_reg_ff);
      end
      ring_size = {1'b0, top_slot} + (SW+1)'(1);
      rows_eff  = (rows_reg_ff == '0) ? srim_pkg::ROWS_W'(1) : rows_reg_ff;
      row_lim   = rows_eff - srim_pkg::ROWS_W'(1);
      row_clamp = (req_ch.row > row_lim) ? row_lim : req_ch.row;
   end

   // ring stepping and history count
   always_comb begin
      head_next = (head_ff == top_slot) ? '0 : head_ff + SW'(1);
      bot_next  = (bot_ff == top_slot) ? '0 : bot_ff + SW'(1);
      base_next = (base_ff == top_slot) ? '0 : base_ff + SW'(1);
      head_prev = (head_ff == '0) ? top_slot : head_ff - SW'(1);
      if (head_ff >= base_ff) begin
         hist_cnt = head_ff - base_ff;
      end else begin
         hist_cnt = SW'({1'b0, head_ff} + ring_size - {1'b0, base_ff});
      end
   end

   // offset move with clamp to 0..history count
   always_comb begin
      ofs_sum   = srim_pkg::OFS_SUM_W'($signed({1'b0, offset_ff}))
                + srim_pkg::OFS_SUM_W'(delta_ff);
      hist_wide = $signed(srim_pkg::OFS_SUM_W'(hist_cnt));
      if (ofs_sum[srim_pkg::OFS_SUM_W-1]) begin
         ofs_clamped = '0;
      end else if (ofs_sum > hist_wide) begin
         ofs_clamped = hist_cnt;
      end else begin
         ofs_clamped = SW'(ofs_sum);
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      delta_in     = delta_ff;
      cnt_in       = cnt_ff;
      head_in      = head_ff;
      base_in      = base_ff;
      offset_in    = offset_ff;
      bot_in       = bot_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      mod_start    = 1'b0;
      mod_value    = '0;
      rsp_load     = 1'b0;
      req_ch.ready = 1'b0;
      case (state_ff)
         srim_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               op_in    = req_ch.opcode;
               delta_in = req_ch.delta;
               slot_in  = '0;
               count_in = '0;
               state_in = srim_pkg::ST_FINISH;
               case (req_ch.opcode)
                  srim_pkg::OP_SCROLL: begin
                     if (req_ch.delta[srim_pkg::DELTA_W-1]) begin
                        cnt_in   = srim_pkg::CNT_W'(-req_ch.delta);
                        state_in = srim_pkg::ST_BACK;
                     end else if (req_ch.delta != '0) begin
                        // screen bottom slot first, then step it with the head
                        cnt_in    = srim_pkg::CNT_W'(req_ch.delta);
                        mod_start = 1'b1;
                        mod_value = srim_pkg::VAL_W'(head_ff) + srim_pkg::VAL_W'(rows_eff);
                        state_in  = srim_pkg::ST_MODWAIT;
                     end
                  end
                  srim_pkg::OP_MOVE_OFS: state_in = srim_pkg::ST_OFFSET;
                  srim_pkg::OP_RESET_OFS: offset_in = '0;
                  srim_pkg::OP_MAP_SCREEN: begin
                     mod_start = 1'b1;
                     mod_value = srim_pkg::VAL_W'(head_ff) + srim_pkg::VAL_W'(row_clamp);
                     state_in  = srim_pkg::ST_MODWAIT;
                  end
                  srim_pkg::OP_MAP_VISIBLE: begin
                     // add the ring size to keep head - offset non-negative
                     mod_start = 1'b1;
                     mod_value = srim_pkg::VAL_W'(head_ff) + srim_pkg::VAL_W'(ring_size)
                               - srim_pkg::VAL_W'(offset_ff) + srim_pkg::VAL_W'(row_clamp);
                     state_in  = srim_pkg::ST_MODWAIT;
                  end
                  default: ;
               endcase
            end
         end
         srim_pkg::ST_MODWAIT: begin
            if (mod_status.done) begin
               if (op_ff == srim_pkg::OP_SCROLL) begin
                  bot_in   = mod_rem;
                  state_in = srim_pkg::ST_FWD;
               end else begin
                  slot_in  = mod_rem;
                  state_in = srim_pkg::ST_FINISH;
               end
            end
         end
         srim_pkg::ST_FWD: begin
            head_in = head_next;
            bot_in  = bot_next;
            // bottom meets base: recycle the oldest line
            if (bot_next == base_ff) begin
               base_in = base_next;
               if (count_ff == '0) begin
                  slot_in = bot_next;
               end
               count_in = count_ff + srim_pkg::CNT_W'(1);
            end
            cnt_in = cnt_ff - srim_pkg::CNT_W'(1);
            if (cnt_ff == srim_pkg::CNT_W'(1)) begin
               state_in = srim_pkg::ST_FINISH;
            end
         end
         srim_pkg::ST_BACK: begin
            if (head_ff == base_ff) begin
               state_in = srim_pkg::ST_FINISH;
            end else begin
               head_in = head_prev;
               cnt_in  = cnt_ff - srim_pkg::CNT_W'(1);
               if (cnt_ff == srim_pkg::CNT_W'(1)) begin
                  state_in = srim_pkg::ST_FINISH;
               end
            end
         end
         srim_pkg::ST_OFFSET: begin
            offset_in = ofs_clamped;
            state_in  = srim_pkg::ST_FINISH;
         end
         srim_pkg::ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = srim_pkg::ST_IDLE;
            end
         end
         default: state_in = srim_pkg::ST_IDLE;
      endcase
      if (csr_wr_en && csr_index == srim_pkg::REG_HISTORY) begin
         head_in   = SW'(1);
         base_in   = SW'(1);
         offset_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srim_pkg::ST_IDLE;
         head_ff      <= SW'(1);
         base_ff      <= SW'(1);
         offset_ff    <= '0;
         hist_reg_ff  <= srim_pkg::HIST_RESET;
         rows_reg_ff  <= srim_pkg::ROWS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         base_ff   <= base_in;
         offset_ff <= offset_in;
         if (csr_wr_en) begin
            case (csr_index)
               srim_pkg::REG_HISTORY: hist_reg_ff <= srim_pkg::HIST_W'(csr_wr_data);
               srim_pkg::REG_ROWS:    rows_reg_ff <= srim_pkg::ROWS_W'(csr_wr_data);
               default: ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      delta_ff <= delta_in;
      cnt_ff   <= cnt_in;
      bot_ff   <= bot_in;
      slot_ff  <= slot_in;
      count_ff <= count_in;
      if (rsp_load) begin
         rsp_slot_ff  <= srim_pkg::FIELD_W'(slot_ff);
         rsp_count_ff <= srim_pkg::FIELD_W'(count_ff);
         rsp_hist_ff  <= srim_pkg::FIELD_W'(hist_cnt);
         rsp_ofs_ff   <= srim_pkg::FIELD_W'(offset_ff);
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.line_slot      = rsp_slot_ff;
   assign rsp_ch.recycled_count = rsp_count_ff;
   assign rsp_ch.history_count  = rsp_hist_ff;
   assign rsp_ch.view_offset    = rsp_ofs_ff;

   `SRIM_ASSERT_IMP(a_fwd_cnt_live, clock, reset, state_ff == srim_pkg::ST_FWD, cnt_ff != '0)
   `SRIM_ASSERT_IMP(a_ofs_in_ring, clock, reset, 1'b1, {1'b0, offset_ff} < ring_size)
   `SRIM_ASSERT_IMP(a_ptrs_in_ring, clock, reset, 1'b1, head_ff <= top_slot && base_ff <= top_slot)
   `SRIM_ASSERT_IMP(a_mod_busy_wait, clock, reset, mod_status.busy, state_ff == srim_pkg::ST_MODWAIT)

endmodule

/* tb/tb_scrollback_ring_index_manager_core.sv */
module tb_scrollback_ring_index_manager_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [srim_pkg::OP_W-1:0] OP_UNUSED_LO =
      srim_pkg::OP_W'(srim_pkg::OP_MAP_VISIBLE + 1);
   localparam logic [srim_pkg::OP_W-1:0] OP_UNUSED_HI = '1;
   localparam int DELTA_MAX = (1 << (srim_pkg::DELTA_W - 1)) - 1;
   localparam int DELTA_MIN = -(1 << (srim_pkg::DELTA_W - 1));
   localparam int NUM_PHASES = 13;
   localparam int PHASE_ITEMS = 85;

   typedef struct packed {
      logic [srim_pkg::OP_W-1:0]           opcode;
      logic signed [srim_pkg::DELTA_W-1:0] delta;
      logic [srim_pkg::ROWS_W-1:0]         row;
   } ring_cmd_type;

   typedef struct packed {
      logic [srim_pkg::FIELD_W-1:0] line_slot;
      logic [srim_pkg::FIELD_W-1:0] recycled_count;
      logic [srim_pkg::FIELD_W-1:0] history_count;
      logic [srim_pkg::FIELD_W-1:0] view_offset;
   } ring_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_wr_en = 1'b0;
   logic [srim_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [srim_pkg::CSR_DATA_W-1:0] csr_wr_data = '0;

   srim_req_if req_if();
   srim_rsp_if rsp_if();

   scrollback_ring_index_manager_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // pointer state and registers as the block should hold them
   logic [srim_pkg::HIST_W-1:0] hist_reg;
   logic [srim_pkg::ROWS_W-1:0] rows_reg;
   logic [srim_pkg::SLOT_W-1:0] head_pos;
   logic [srim_pkg::SLOT_W-1:0] base_pos;
   logic [srim_pkg::SLOT_W-1:0] view_ofs;

   ring_cmd_type    cmd_queue[$];
   ring_result_type ring_results[$];
   ring_cmd_type    drive_cmd;

   int queued_total = 0;
   int accepted_total = 0;
   int checked_total = 0;
   int fail_count = 0;
   int recycled_total = 0;
   int settings_used = 0;
   bit req_taken = 1'b0;
   int burst_left = 1;
   int gap_left = 0;
   logic [31:0] stall_pat = '1;
   int stall_tick = 0;

   int cfg_hist [NUM_PHASES] = '{1, 0, 2, 5, 13, 31, 64, 1023, 200, 9, -1, 0, 0};
   int cfg_rows [NUM_PHASES] = '{1, 0, 3, 4, 13, 8, 24, 255, 255, 1, 2, 0, 0};

   always #2 clock = ~clock;

   function automatic int ring_top();
      return (hist_reg == '0) ? 1 : int'(hist_reg);
   endfunction

   function automatic int rows_eff();
      return (rows_reg == '0) ? 1 : int'(rows_reg);
   endfunction

   function automatic ring_result_type advance_ring(ring_cmd_type c);
      ring_result_type r;
      int top, n, rows, d, h, b, o, v, rowc, count, i;
      top = ring_top();
      n = top + 1;
      rows = rows_eff();
      d = int'($signed(c.delta));
      h = int'(head_pos);
      b = int'(base_pos);
      o = int'(view_ofs);
      rowc = (int'(c.row) > rows - 1) ? rows - 1 : int'(c.row);
      count = 0;
      r = '0;
      case (c.opcode)
         srim_pkg::OP_SCROLL: begin
            if (d < 0) begin
               // step back, stop at the oldest line
               for (i = d; i < 0; i++) begin
                  if (h == b) break;
                  h = (h == 0) ? top : h - 1;
               end
            end else begin
               for (i = 0; i < d; i++) begin
                  h = (h == top) ? 0 : h + 1;
                  v = (h + rows) % n;
                  if (v == b) begin
                     b = (b == top) ? 0 : b + 1;
                     if (count == 0) r.line_slot = srim_pkg::FIELD_W'(v);
                     count++;
                  end
               end
            end
         end
         srim_pkg::OP_MOVE_OFS: begin
            v = o + d;
            if (v < 0) v = 0;
            if (v > (h + n - b) % n) v = (h + n - b) % n;
            o = v;
         end
         srim_pkg::OP_RESET_OFS: o = 0;
         srim_pkg::OP_MAP_SCREEN: r.line_slot = srim_pkg::FIELD_W'((h + rowc) % n);
         srim_pkg::OP_MAP_VISIBLE: begin
            v = (h - o + rowc) % n;
            if (v < 0) v += n;
            r.line_slot = srim_pkg::FIELD_W'(v);
         end
         default: ;
      endcase
      head_pos = srim_pkg::SLOT_W'(h);
      base_pos = srim_pkg::SLOT_W'(b);
      view_ofs = srim_pkg::SLOT_W'(o);
      recycled_total += count;
      r.recycled_count = srim_pkg::FIELD_W'(count);
      r.history_count = srim_pkg::FIELD_W'((h + n - b) % n);
      r.view_offset = srim_pkg::FIELD_W'(o);
      return r;
   endfunction

   function automatic void check_field(string name, logic [srim_pkg::FIELD_W-1:0] want,
                                       logic [srim_pkg::FIELD_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic ring_cmd_type random_cmd();
      ring_cmd_type c;
      int pick, n, span, d;
      n = ring_top() + 1;
      // small rings (up to 64 slots) get deltas that wrap; larger rings get short moves
      span = (n <= 64) ? n + rows_eff() : 40;
      pick = $urandom_range(0, 99);
      c.row = pick[0] ? srim_pkg::ROWS_W'($urandom)
                      : srim_pkg::ROWS_W'($urandom_range(0, rows_eff() + 1));
      d = $urandom_range(0, span);
      if (pick < 35) begin
         c.opcode = srim_pkg::OP_SCROLL;
      end else if (pick < 50) begin
         c.opcode = srim_pkg::OP_SCROLL;
         d = -d;
      end else if (pick < 65) begin
         c.opcode = srim_pkg::OP_MOVE_OFS;
         d = $urandom_range(0, 2 * span) - span;
      end else begin
         d = $urandom_range(0, DELTA_MAX - DELTA_MIN) + DELTA_MIN;
         if (pick < 70) c.opcode = srim_pkg::OP_RESET_OFS;
         else if (pick < 83) c.opcode = srim_pkg::OP_MAP_SCREEN;
         else if (pick < 95) c.opcode = srim_pkg::OP_MAP_VISIBLE;
         else if (pick < 98)
            c.opcode = srim_pkg::OP_W'($urandom_range(srim_pkg::OP_SCROLL,
                                                      srim_pkg::OP_MAP_VISIBLE));
         else c.opcode = srim_pkg::OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end
      c.delta = srim_pkg::DELTA_W'(d);
      return c;
   endfunction

   task automatic queue_cmd(logic [srim_pkg::OP_W-1:0] op, int d, int r);
      ring_cmd_type c;
      c.opcode = op;
      c.delta = srim_pkg::DELTA_W'(d);
      c.row = srim_pkg::ROWS_W'(r);
      cmd_queue.push_back(c);
      queued_total++;
   endtask

   task automatic write_csr(srim_pkg::csr_index_type idx,
                            logic [srim_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == srim_pkg::REG_HISTORY) begin
         hist_reg = data[srim_pkg::HIST_W-1:0];
         head_pos = srim_pkg::SLOT_W'(1);
         base_pos = srim_pkg::SLOT_W'(1);
         view_ofs = '0;
      end else begin
         rows_reg = data[srim_pkg::ROWS_W-1:0];
      end
   endtask

   task automatic wait_drained();
      while (cmd_queue.size() != 0 || accepted_total != queued_total ||
             ring_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // sender: bursts of transfers separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_taken = 1'b0;
      end else if (!req_if.valid || req_taken) begin
         req_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (cmd_queue.size() == 0) begin
            req_if.valid <= 1'b0;
         end else begin
            drive_cmd = cmd_queue.pop_front();
            req_if.valid <= 1'b1;
            req_if.opcode <= drive_cmd.opcode;
            req_if.delta <= drive_cmd.delta;
            req_if.row <= drive_cmd.row;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
   end

   // receiver: rotate a stall pattern, reload it each time the tick counter wraps
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (stall_tick == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pat = '1;
               1: stall_pat = $urandom;
               2: stall_pat = $urandom | $urandom;
               default: stall_pat = $urandom & $urandom;
            endcase
         end else begin
            stall_pat = {stall_pat[0], stall_pat[31:1]};
         end
         stall_tick = (stall_tick + 1) % 64;
         rsp_if.ready <= stall_pat[0];
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            ring_results.push_back(advance_ring(ring_cmd_type'{req_if.opcode, req_if.delta,
                                                               req_if.row}));
            accepted_total++;
            req_taken = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (ring_results.size() == 0) begin
               $error("result transfer with no command outstanding");
               fail_count++;
            end else begin
               ring_result_type want;
               want = ring_results.pop_front();
               check_field("line_slot", want.line_slot, rsp_if.line_slot);
               check_field("recycled_count", want.recycled_count, rsp_if.recycled_count);
               check_field("history_count", want.history_count, rsp_if.history_count);
               check_field("view_offset", want.view_offset, rsp_if.view_offset);
            end
            checked_total++;
         end
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.opcode = '0;
      req_if.delta = '0;
      req_if.row = '0;
      rsp_if.ready = 1'b0;
      hist_reg = srim_pkg::HIST_RESET;
      rows_reg = srim_pkg::ROWS_RESET;
      head_pos = srim_pkg::SLOT_W'(1);
      base_pos = srim_pkg::SLOT_W'(1);
      view_ofs = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      settings_used = 1;

      // directed checks on the reset settings
      queue_cmd(srim_pkg::OP_MAP_SCREEN, 0, 0);
      queue_cmd(srim_pkg::OP_MAP_SCREEN, 0, 255);
      queue_cmd(srim_pkg::OP_MAP_VISIBLE, 0, 255);
      queue_cmd(srim_pkg::OP_MOVE_OFS, 5, 0);
      queue_cmd(srim_pkg::OP_SCROLL, DELTA_MIN, 0);
      queue_cmd(srim_pkg::OP_SCROLL, 30, 0);
      queue_cmd(srim_pkg::OP_MOVE_OFS, DELTA_MAX, 0);
      queue_cmd(srim_pkg::OP_MAP_VISIBLE, 0, 0);
      // offset stays above the shrunken history
      queue_cmd(srim_pkg::OP_SCROLL, -20, 0);
      queue_cmd(srim_pkg::OP_MAP_VISIBLE, 0, 3);
      queue_cmd(srim_pkg::OP_MOVE_OFS, DELTA_MIN, 0);
      queue_cmd(srim_pkg::OP_MOVE_OFS, 7, 0);
      queue_cmd(srim_pkg::OP_RESET_OFS, DELTA_MAX, 255);
      queue_cmd(srim_pkg::OP_SCROLL, DELTA_MAX, 0);
      queue_cmd(srim_pkg::OP_SCROLL, DELTA_MAX, 0);
      queue_cmd(srim_pkg::OP_MAP_SCREEN, 0, 23);
      queue_cmd(srim_pkg::OP_MAP_VISIBLE, 0, 24);
      queue_cmd(srim_pkg::OP_SCROLL, 0, 0);
      queue_cmd(OP_UNUSED_LO, -1, 255);
      queue_cmd(srim_pkg::OP_W'(OP_UNUSED_LO + 1), DELTA_MAX, 0);
      queue_cmd(OP_UNUSED_HI, DELTA_MIN, 170);
      queue_cmd(srim_pkg::OP_MOVE_OFS, DELTA_MAX, 0);
      queue_cmd(srim_pkg::OP_MAP_VISIBLE, 0, 128);
      wait_drained();

      for (int k = 0; k < NUM_PHASES; k++) begin
         if (k >= NUM_PHASES - 2) begin
            cfg_hist[k] = $urandom_range(0, 80);
            cfg_rows[k] = $urandom_range(0, 255);
         end
         // a negative history entry keeps the ring and changes rows only
         if (cfg_hist[k] >= 0)
            write_csr(srim_pkg::REG_HISTORY, srim_pkg::CSR_DATA_W'(cfg_hist[k]));
         write_csr(srim_pkg::REG_ROWS, {2'($urandom), srim_pkg::ROWS_W'(cfg_rows[k])});
         settings_used++;
         for (int j = 0; j < PHASE_ITEMS; j++) begin
            cmd_queue.push_back(random_cmd());
            queued_total++;
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      $display("Checked %0d result transfers over %0d register settings, all opcodes.",
               checked_total, settings_used);
      $display("Forward scrolls recycled %0d ring slots in total.", recycled_total);
      if (fail_count == 0) begin
         $display("** scrollback_ring_index_manager_core: PASSED **");
      end else begin
         $display("** scrollback_ring_index_manager_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #(20_000_000);
      $error("run did not complete in time");
      $display("** scrollback_ring_index_manager_core: FAILED **");
      $finish;
   end

endmodule
